// File: design/lkvc_pkg.sv
package lkvc_pkg;

	// Default number of cells in the chain.
	localparam int ENTRIES_DEF = 16;

	// Field widths fixed by the interface.
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int CAP_W  = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Update applied by every cell in the commit cycle.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_HIT_GET,
		OP_HIT_SET,
		OP_EVICT,
		OP_INSERT
	} cell_op_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic             update;
		cell_op_t         op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

// File: design/lkvc_cell.sv
module lkvc_cell #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
	parameter int IDX     = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  lkvc_pkg::cell_cmd_t                           cmd,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] ref_rank,
	input  logic [$clog2(ENTRIES+1)-1:0]                  fill,
	input  logic                                          in_hit,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] in_rank,
	input  logic [lkvc_pkg::VAL_W-1:0]                    in_value,
	output logic                                          out_hit,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] out_rank,
	output logic [lkvc_pkg::VAL_W-1:0]                    out_value,
	output logic                                          match,
	output logic                                          valid
);
	import lkvc_pkg::*;

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES+1);

	logic             valid_q;
	logic [RW-1:0]    rank_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             out_hit_q;
	logic [RW-1:0]    out_rank_q;
	logic [VAL_W-1:0] out_value_q;
	logic             younger;
	logic             is_next_free;

	// This cell holds the key being looked up.
	assign match        = valid_q && (key_q == cmd.key);
	assign younger      = valid_q && (rank_q < ref_rank);
	assign is_next_free = (fill == CW'(IDX));
	assign valid        = valid_q;

	// Hit search: the first match seen along the chain is handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_hit_q <= 1'b0;
		end else begin
			out_hit_q <= in_hit || match;
		end
	end

	always_ff @(posedge clk) begin
		if (in_hit) begin
			out_rank_q  <= in_rank;
			out_value_q <= in_value;
		end else begin
			out_rank_q  <= rank_q;
			out_value_q <= value_q;
		end
	end

	assign out_hit   = out_hit_q;
	assign out_rank  = out_rank_q;
	assign out_value = out_value_q;

	// Recency and occupancy update in the commit cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.update) begin
			case (cmd.op)
				OP_HIT_GET, OP_HIT_SET: begin
					if (match) begin
						rank_q <= '0;
					end else if (younger) begin
						rank_q <= rank_q + RW'(1);
					end
				end
				OP_EVICT: begin
					if (valid_q && rank_q == ref_rank) begin
						rank_q <= '0;
					end else if (younger) begin
						rank_q <= rank_q + RW'(1);
					end
				end
				OP_INSERT: begin
					if (is_next_free) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end else if (valid_q) begin
						rank_q <= rank_q + RW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key and value storage.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			case (cmd.op)
				OP_HIT_SET: begin
					if (match) begin
						value_q <= cmd.value;
					end
				end
				OP_EVICT: begin
					if (valid_q && rank_q == ref_rank) begin
						key_q   <= cmd.key;
						value_q <= cmd.value;
					end
				end
				OP_INSERT: begin
					if (is_next_free) begin
						key_q   <= cmd.key;
						value_q <= cmd.value;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement,
// built as a chain of ENTRIES cells, each holding one key, its value and its
// recency rank. An item is a get (tuser 0) or a set (tuser 1) of a 32-bit key
// and value; every item gives exactly one result. The lookup walks the chain
// one cell per cycle: an item is taken in the idle state, the hit search
// crosses the chain in the scan state, and in the commit cycle all cells
// update their ranks together; the commit waits while a result is pending.
// The next item is taken after the commit, while its result may still wait
// in the output register. Capacity is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle, which the block does not
// enforce. Values above ENTRIES act as ENTRIES and zero disables the cache. Reset needs no clearing pass.
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,   // capacity
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,     // key [31:0], value [63:32]
	input  logic                       s_tuser,     // mode: 0 get, 1 set
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata      // hit, read_value, evicted, zero pad
);
	import lkvc_pkg::*;

	localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES+1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0]       state_q;
	logic [RW-1:0]    scan_cnt_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CW-1:0]    fill_q;
	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic             res_valid_q;
	logic             res_hit_q;
	logic [VAL_W-1:0] res_value_q;
	logic             res_evicted_q;

	logic             chain_hit   [0:ENTRIES];
	logic [RW-1:0]    chain_rank  [0:ENTRIES];
	logic [VAL_W-1:0] chain_value [0:ENTRIES];
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] valid_vec;

	cell_cmd_t        cmd;
	cell_op_t         op;
	logic [RW-1:0]    ref_rank;
	logic [CMPW-1:0]  cap_ext;
	logic [CMPW-1:0]  cap_eff;
	logic             cap_zero;
	logic             full;
	logic             commit;
	logic             found;

	assign s_tready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_UPDATE) && (!res_valid_q || m_tready);

	// Effective capacity, saturated at the number of cells.
	assign cap_ext  = CMPW'(capacity_q);
	assign cap_eff  = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
	assign cap_zero = (capacity_q == '0);
	assign full     = (CMPW'(fill_q) >= cap_eff);
	assign found    = chain_hit[ENTRIES];

	// Choose the update that every cell applies.
	always_comb begin
		op = OP_NONE;
		if (!cap_zero) begin
			if (found) begin
				op = mode_q ? OP_HIT_SET : OP_HIT_GET;
			end else if (mode_q) begin
				op = full ? OP_EVICT : OP_INSERT;
			end
		end
	end

	// The hit moves its own rank; an eviction takes the least recent rank.
	assign ref_rank = found ? chain_rank[ENTRIES] : RW'(fill_q - CW'(1));

	assign cmd.update = commit;
	assign cmd.op     = op;
	assign cmd.key    = key_q;
	assign cmd.value  = value_q;

	// Chain of cells.
	assign chain_hit[0]   = 1'b0;
	assign chain_rank[0]  = '0;
	assign chain_value[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.ENTRIES (ENTRIES),
			.IDX     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.ref_rank  (ref_rank),
			.fill      (fill_q),
			.in_hit    (chain_hit[i]),
			.in_rank   (chain_rank[i]),
			.in_value  (chain_value[i]),
			.out_hit   (chain_hit[i+1]),
			.out_rank  (chain_rank[i+1]),
			.out_value (chain_value[i+1]),
			.match     (match_vec[i]),
			.valid     (valid_vec[i])
		);
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Sequencer: take an item, let the search cross the chain, then commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			fill_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q    <= ST_SCAN;
						scan_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_cnt_q == RW'(ENTRIES - 1)) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_cnt_q <= scan_cnt_q + RW'(1);
					end
				end
				ST_UPDATE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (op == OP_INSERT) begin
							fill_q <= fill_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q  <= s_tuser;
			key_q   <= s_tdata[31:0];
			value_q <= s_tdata[63:32];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_hit_q     <= (op == OP_HIT_GET) || (op == OP_HIT_SET);
			res_value_q   <= (op == OP_HIT_GET) ? chain_value[ENTRIES] : '1;
			res_evicted_q <= (op == OP_EVICT);
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {6'd0, res_evicted_q, res_value_q, res_hit_q};

`ifndef ASSERT_OFF
	// Keys are unique, so at most one cell matches.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the key");

	// The fill count tracks the occupied cells.
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_q))
		else $error("fill count differs from occupied cells");

	// A committed item presents its result in the next cycle.
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("result missing after commit");

	// A result is never both a hit and an eviction.
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
		else $error("hit and eviction reported together");
`endif

endmodule
